// ----- design/fmpr_pkg.sv -----
package fmpr_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int PAYLOAD_BITS = 32;
   localparam int PRIO_BITS    = 9;
   localparam int IDX_BITS     = $clog2(QUEUE_DEPTH);
   localparam int COUNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int OP_BITS      = 2;

   // Stream bus widths, rounded up to whole bytes.
   localparam int IN_BITS  = ((PAYLOAD_BITS + PRIO_BITS + 7) / 8) * 8;
   localparam int OUT_RAW  = PAYLOAD_BITS + PRIO_BITS + COUNT_BITS + 2;
   localparam int OUT_BITS = ((OUT_RAW + 7) / 8) * 8;

   localparam logic [OP_BITS-1:0] OP_ENQUEUE = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DEQUEUE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_EXTRACT = 2'd2;
   localparam logic [OP_BITS-1:0] OP_CLEAR   = 2'd3;

   // One stored queue entry.
   typedef struct packed {
      logic [PRIO_BITS-1:0]    prio;
      logic [PAYLOAD_BITS-1:0] pay;
   } entry_type;

   // One operation handed to the core.
   typedef struct packed {
      logic [OP_BITS-1:0] op;
      entry_type          entry;
   } cmd_type;

   // One finished result handed back by the core.
   typedef struct packed {
      logic                  removed_valid;
      entry_type             removed;
      logic [COUNT_BITS-1:0] occupancy;
      logic                  is_empty;
      logic                  rejected_full;
   } result_type;

endpackage

// ----- design/fmpr_core.sv -----
module fmpr_core
   import fmpr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   output logic       cmd_ready,
   input  cmd_type    cmd,
   output logic       res_valid,
   input  logic       res_ready,
   output result_type res
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_SHIFT = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   entry_type mem [QUEUE_DEPTH];

   logic [1:0]            state_ff,    state_in;
   logic [COUNT_BITS-1:0] count_ff,    count_in;
   logic [COUNT_BITS-1:0] scan_end_ff, scan_end_in;
   logic [COUNT_BITS-1:0] issue_ff,    issue_in;
   logic                  rd_vld_ff,   rd_vld_in;
   logic [IDX_BITS-1:0]   rd_idx_ff,   rd_idx_in;
   entry_type             rd_data_ff;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   entry_type             best_ff,     best_in;
   result_type            res_ff,      res_in;

   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   entry_type             wr_data;
   logic [COUNT_BITS-1:0] count_dec;

   assign cmd_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;
   assign count_dec = count_ff - 1'b1;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_end_in = scan_end_ff;
      issue_in    = issue_ff;
      rd_vld_in   = 1'b0;
      rd_idx_in   = rd_idx_ff;
      best_idx_in = best_idx_ff;
      best_in     = best_ff;
      res_in      = res_ff;
      wr_en       = 1'b0;
      wr_addr     = count_ff[IDX_BITS-1:0];
      wr_data     = cmd.entry;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               res_in = '0;
               case (cmd.op)
                  OP_ENQUEUE: begin
                     if (count_ff == COUNT_BITS'(QUEUE_DEPTH)) begin
                        res_in.rejected_full = 1'b1;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                     res_in.occupancy = count_in;
                     res_in.is_empty  = (count_in == '0);
                     state_in         = S_DONE;
                  end
                  OP_CLEAR: begin
                     count_in        = '0;
                     res_in.is_empty = 1'b1;
                     state_in        = S_DONE;
                  end
                  default: begin
                     // Dequeue looks at the front entry only; extract scans them all.
                     if (count_ff == '0) begin
                        res_in.is_empty = 1'b1;
                        state_in        = S_DONE;
                     end else begin
                        scan_end_in = (cmd.op == OP_EXTRACT) ? count_ff : COUNT_BITS'(1);
                        issue_in    = '0;
                        state_in    = S_SCAN;
                     end
                  end
               endcase
            end
         end

         S_SCAN: begin
            if (issue_ff < scan_end_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IDX_BITS-1:0];
               issue_in  = issue_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               // Strictly greater keeps the earliest entry on a tie.
               if (rd_idx_ff == '0 || rd_data_ff.prio > best_ff.prio) begin
                  best_in     = rd_data_ff;
                  best_idx_in = rd_idx_ff;
               end
               if (COUNT_BITS'(rd_idx_ff) == scan_end_ff - 1'b1) begin
                  rd_vld_in = 1'b0;
                  issue_in  = COUNT_BITS'(best_idx_in) + 1'b1;
                  state_in  = S_SHIFT;
               end
            end
         end

         S_SHIFT: begin
            if (issue_ff < count_ff) begin
               rd_vld_in = 1'b1;
               rd_idx_in = issue_ff[IDX_BITS-1:0];
               issue_in  = issue_ff + 1'b1;
            end
            if (rd_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = IDX_BITS'(rd_idx_ff - 1'b1);
               wr_data = rd_data_ff;
            end
            if (issue_ff >= count_ff && !rd_vld_ff) begin
               count_in             = count_dec;
               res_in.removed_valid = 1'b1;
               res_in.removed       = best_ff;
               res_in.occupancy     = count_dec;
               res_in.is_empty      = (count_dec == '0);
               res_in.rejected_full = 1'b0;
               state_in             = S_DONE;
            end
         end

         default: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_idx_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_vld_ff <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_end_ff <= scan_end_in;
      issue_ff    <= issue_in;
      rd_idx_ff   <= rd_idx_in;
      best_idx_ff <= best_idx_in;
      best_ff     <= best_in;
      res_ff      <= res_in;
   end

endmodule

// ----- design/fifo_with_max_priority_removal.sv -----
// Channel   Direction  Handshake              Contents
// req_      in         req_tvalid/req_tready  one queue operation per transaction
// rsp_      out        rsp_tvalid/rsp_tready  one result per operation
//
// Enqueue, clear and a removal from an empty queue go from acceptance straight
// to the core's result register and from there into the output register; the
// core accepts the next operation once that result has been handed over.
// Dequeue and extract sweep the single read port of the entry memory once to
// find the maximum and once more to close up the entries behind the removed
// one; dequeue reads only the front entry in the first sweep and so closes up
// the whole queue in the second.
// Reset empties the queue at once; the entry memory itself is not cleared.
// The result sits in an output register, so a new operation is accepted
// while an earlier result still waits for rsp_tready; the core stalls only
// when a second result is ready before the first one has drained.
module fifo_with_max_priority_removal
   import fmpr_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   // [31:0] entry_payload, [40:32] entry_priority, upper bits zero.
   input  logic [IN_BITS-1:0]      req_tdata,
   // [1:0] opcode.
   input  logic [OP_BITS-1:0]      req_tuser,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [31:0] removed_payload, [40:32] removed_priority, [45:41] occupancy,
   // [46] is_empty, [47] rejected_full.
   output logic [OUT_BITS-1:0]     rsp_tdata,
   // [0] removed_valid.
   output logic                    rsp_tuser
);

   cmd_type    cmd;
   logic       core_ready;
   logic       res_valid;
   logic       res_ready;
   result_type res;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff;

   // The operation is decoded straight from the request bus.
   assign cmd.op          = req_tuser;
   assign cmd.entry.pay   = req_tdata[PAYLOAD_BITS-1:0];
   assign cmd.entry.prio  = req_tdata[PAYLOAD_BITS +: PRIO_BITS];
   assign req_tready      = core_ready;

   fmpr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_ready (core_ready),
      .cmd       (cmd),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // The output register takes a new result when it is empty or being drained.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.removed_valid;
   assign rsp_tdata  = OUT_BITS'({rsp_ff.rejected_full,
                                  rsp_ff.is_empty,
                                  rsp_ff.occupancy,
                                  rsp_ff.removed.prio,
                                  rsp_ff.removed.pay});

endmodule
